// ----- design/bts_pkg.sv -----
// Package with the shared constants, types and helpers of the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;

  localparam int TEX_SIDE    = 256;
  localparam int IDX_W       = $clog2(TEX_SIDE);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int TEXEL_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = FRAC_BITS + 2;
  localparam int UCOORD_W    = FRAC_BITS + 1;
  localparam int OUT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Shared multiply-add unit widths.
  localparam int BASE_W      = CHAN_W + FRAC_BITS;
  localparam int DIFF_W      = BASE_W + 2;
  localparam int PROD_W      = DIFF_W + UCOORD_W + 1;

  localparam logic [UCOORD_W-1:0] COORD_ONE = UCOORD_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW    = 2'd1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_U,
    S_SCALE_V,
    S_RD00,
    S_RD10,
    S_RD01,
    S_RD11,
    S_NEAR,
    S_FAR,
    S_TOTAL,
    S_STORE,
    S_FIN
  } seq_state_t;

  // One operation for the shared unit: result = (base << FRAC_BITS) + diff * mul.
  typedef struct packed {
    logic                     en;
    logic [BASE_W-1:0]        base;
    logic signed [DIFF_W-1:0] diff;
    logic [UCOORD_W-1:0]      mul;
  } mac_op_t;

  function automatic logic [CHAN_W-1:0] texel_byte(input logic [TEXEL_W-1:0] texel,
                                                   input logic [1:0] ch);
    logic [CHAN_W-1:0] b;
    case (ch)
      2'd0:    b = texel[7:0];
      2'd1:    b = texel[15:8];
      2'd2:    b = texel[23:16];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- design/bts_if.sv -----
// Valid/ready channel interfaces for sample requests and filtered results.
`timescale 1ns / 1ps
`default_nettype none
interface bts_in_if
  import bts_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [IDX_W-1:0]          texel_column;
  logic [IDX_W-1:0]          texel_row;
  logic [TEXEL_W-1:0]        texel_value;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;

  modport source (output valid, req_type, texel_column, texel_row, texel_value,
                  coord_u, coord_v, input ready);
  modport sink   (input valid, req_type, texel_column, texel_row, texel_value,
                  coord_u, coord_v, output ready);
endinterface

interface bts_out_if
  import bts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;
  logic             coord_error;

  modport source (output valid, red_out, green_out, blue_out, coord_error, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, coord_error, output ready);
endinterface
`default_nettype wire

// ----- design/bilinear_texture_sampler_unit.sv -----
// Top level of the bilinear texture sampler: sequencer, texture memory and shared unit.
//
// The block keeps a 256 x 256 texture of packed 24-bit texels (red in the low
// byte, blue in the high byte) in a single-port memory. Items arrive on the in_ch
// channel; each accepted beat is either a texel write or a bilinear sample at
// u,v in signed 1.16 fixed point. Every item gives exactly one beat on out_ch:
// a write returns zeros, a sample with a negative coordinate returns zeros with
// coord_error set, and any other sample returns each channel times 256.
// The configuration port sets the last column and last row indices; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// A write or an erroneous sample goes from idle straight to the finish state. A
// valid sample scales u and v, reads the four neighbouring texels one by one from
// the single memory port, forms the nine blend products and three channel stores,
// and then passes through the finish state to load the output register.
// The block takes one item at a time; in_ch.ready is high only while it is idle.
// The result sits in an output register, so a new item may be accepted while the
// previous result still waits; a finished item then holds in its last state
// until out_ch.ready frees the register. Reset (synchronous, rst_n low) returns
// the sequencer to idle, drops out_ch.valid and sets both limits to 255; the
// texture itself is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_texture_sampler_unit
  import bts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bts_in_if.sink                     in_ch,
  bts_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;

  logic [IDX_W-1:0]     last_col_r;
  logic [IDX_W-1:0]     last_row_r;

  logic [UCOORD_W-1:0]  cu_r;
  logic [UCOORD_W-1:0]  cv_r;
  logic [IDX_W-1:0]     ul_r, ur_r, vl_r, vr_r;
  logic [FRAC_BITS-1:0] fu_r, fv_r;
  logic [TEXEL_W-1:0]   t00_r, t10_r, t01_r, t11_r;
  logic [BASE_W-1:0]    near_r;
  logic [1:0]           ch_r;
  logic [OUT_W-1:0]     red_r, green_r, blue_r;
  logic                 err_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 out_free;
  logic                 ram_en, ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [TEXEL_W-1:0]   ram_rdata;
  mac_op_t              mac_op;
  logic signed [PROD_W-1:0] mac_p;

  logic [IDX_W-1:0]     p_idx;
  logic [FRAC_BITS-1:0] p_frac;
  logic [IDX_W-1:0]     v_far;
  logic [CHAN_W-1:0]    ch_a, ch_b, ch_c, ch_d;
  logic [OUT_W-1:0]     chan_val;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Integer and fraction parts of a scaled coordinate held in the shared unit.
  assign p_idx    = mac_p[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign p_frac   = mac_p[FRAC_BITS-1:0];
  assign v_far    = (p_idx != last_row_r) ? p_idx + 1'b1 : p_idx;

  // The last far-row texel arrives on the memory output while the first near row is blended.
  assign ch_a     = texel_byte(t00_r, ch_r);
  assign ch_b     = texel_byte(t10_r, ch_r);
  assign ch_c     = texel_byte(t01_r, ch_r);
  assign ch_d     = texel_byte(t11_r, ch_r);
  assign chan_val = mac_p[2*FRAC_BITS-CHAN_W+OUT_W-1:2*FRAC_BITS-CHAN_W];

  bts_tex_ram u_tex_ram (
    .clk     (clk),
    .en      (ram_en),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (in_ch.texel_value),
    .rdata_r (ram_rdata)
  );

  bts_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .p_r (mac_p)
  );

  // Sequencer: next state, memory port and the operation for the shared unit.
  always_comb begin
    state_nxt = state_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {in_ch.texel_row, in_ch.texel_column};
    mac_op    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.req_type == REQ_WRITE) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            state_nxt = S_FIN;
          end else if (in_ch.coord_u[COORD_W-1] || in_ch.coord_v[COORD_W-1]) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCALE_U;
          end
        end
      end
      S_SCALE_U: begin
        mac_op.en   = 1'b1;
        mac_op.diff = $signed({{(DIFF_W-IDX_W){1'b0}}, last_col_r});
        mac_op.mul  = cu_r;
        state_nxt   = S_SCALE_V;
      end
      S_SCALE_V: begin
        mac_op.en   = 1'b1;
        mac_op.diff = $signed({{(DIFF_W-IDX_W){1'b0}}, last_row_r});
        mac_op.mul  = cv_r;
        state_nxt   = S_RD00;
      end
      S_RD00: begin
        ram_en    = 1'b1;
        ram_addr  = {p_idx, ul_r};
        state_nxt = S_RD10;
      end
      S_RD10: begin
        ram_en    = 1'b1;
        ram_addr  = {vl_r, ur_r};
        state_nxt = S_RD01;
      end
      S_RD01: begin
        ram_en    = 1'b1;
        ram_addr  = {vr_r, ul_r};
        state_nxt = S_RD11;
      end
      S_RD11: begin
        ram_en    = 1'b1;
        ram_addr  = {vr_r, ur_r};
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        mac_op.en   = 1'b1;
        mac_op.base = BASE_W'(ch_a);
        mac_op.diff = DIFF_W'($signed({1'b0, ch_b}) - $signed({1'b0, ch_a}));
        mac_op.mul  = {1'b0, fu_r};
        state_nxt   = S_FAR;
      end
      S_FAR: begin
        mac_op.en   = 1'b1;
        mac_op.base = BASE_W'(ch_c);
        mac_op.diff = DIFF_W'($signed({1'b0, ch_d}) - $signed({1'b0, ch_c}));
        mac_op.mul  = {1'b0, fu_r};
        state_nxt   = S_TOTAL;
      end
      S_TOTAL: begin
        mac_op.en   = 1'b1;
        mac_op.base = near_r;
        mac_op.diff = $signed({2'b00, mac_p[BASE_W-1:0]}) - $signed({2'b00, near_r});
        mac_op.mul  = {1'b0, fv_r};
        state_nxt   = S_STORE;
      end
      S_STORE: begin
        state_nxt = (ch_r == 2'd2) ? S_FIN : S_NEAR;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Limit registers; both are 8 bits wide, so they can never exceed the texture side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= IDX_W'(TEX_SIDE - 1);
      last_row_r <= IDX_W'(TEX_SIDE - 1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_LAST_COLUMN) begin
        last_col_r <= cfg_wdata;
      end else if (cfg_index == CFG_LAST_ROW) begin
        last_row_r <= cfg_wdata;
      end
    end
  end

  // Working registers of one item. The channel counter stops on the blue channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= 2'd0;
    end else begin
      if (state_r == S_IDLE) begin
        ch_r <= 2'd0;
      end else if (state_r == S_STORE && ch_r != 2'd2) begin
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // Coordinates above one saturate to exactly one.
      cu_r    <= in_ch.coord_u[FRAC_BITS] ? COORD_ONE : {1'b0, in_ch.coord_u[FRAC_BITS-1:0]};
      cv_r    <= in_ch.coord_v[FRAC_BITS] ? COORD_ONE : {1'b0, in_ch.coord_v[FRAC_BITS-1:0]};
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      err_r   <= (in_ch.req_type == REQ_SAMPLE) &&
                 (in_ch.coord_u[COORD_W-1] || in_ch.coord_v[COORD_W-1]);
    end
    if (state_r == S_SCALE_V) begin
      ul_r <= p_idx;
      ur_r <= (p_idx != last_col_r) ? p_idx + 1'b1 : p_idx;
      fu_r <= p_frac;
    end
    if (state_r == S_RD00) begin
      vl_r <= p_idx;
      vr_r <= v_far;
      fv_r <= p_frac;
    end
    if (state_r == S_RD10) begin
      t00_r <= ram_rdata;
    end
    if (state_r == S_RD01) begin
      t10_r <= ram_rdata;
    end
    if (state_r == S_RD11) begin
      t01_r <= ram_rdata;
    end
    if (state_r == S_NEAR && ch_r == 2'd0) begin
      t11_r <= ram_rdata;
    end
    if (state_r == S_FAR) begin
      near_r <= mac_p[BASE_W-1:0];
    end
    if (state_r == S_STORE) begin
      case (ch_r)
        2'd0:    red_r   <= chan_val;
        2'd1:    green_r <= chan_val;
        default: blue_r  <= chan_val;
      endcase
    end
  end

  // Output register: a finished item is loaded once the previous beat has gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_ch.red_out     <= red_r;
      out_ch.green_out   <= green_r;
      out_ch.blue_out    <= blue_r;
      out_ch.coord_error <= err_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  // The blended total of a channel is never negative and fits 40 bits.
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE |-> mac_p[PROD_W-1:2*FRAC_BITS+CHAN_W] == '0)
    else $error("blend total out of range");

  // Only three colour channels are ever processed.
  a_chan_count: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r != 2'd3)
    else $error("channel counter overran");

  // A result beat appears only after the sequencer has finished an item.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish state");

  // The far column never passes the last column.
  a_far_col: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD10 |-> ur_r <= last_col_r && ul_r <= ur_r)
    else $error("far column beyond limit");

  // The texture is written only on an accepted write beat.
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && in_ch.req_type == REQ_WRITE && $past(state_r != S_FIN) ||
      state_r == S_IDLE && in_ch.req_type == REQ_WRITE)
    else $error("texture written outside a write beat");

endmodule
`default_nettype wire

// ----- design/bts_tex_ram.sv -----
// Single-port texture memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bts_tex_ram
  import bts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic [TEXEL_W-1:0] wdata,
  output logic      [TEXEL_W-1:0] rdata_r
);

  logic [TEXEL_W-1:0] mem [TEX_SIDE*TEX_SIDE];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/bts_mac.sv -----
// Shared multiply-add unit: one signed product plus a shifted base, registered.
`timescale 1ns / 1ps
`default_nettype none
module bts_mac
  import bts_pkg::*;
(
  input  wire logic                     clk,
  input  wire mac_op_t                  op,
  output logic signed [PROD_W-1:0]      p_r
);

  logic signed [PROD_W-1:0] base_ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_nxt;

  always_comb begin
    base_ext = $signed({{(PROD_W-BASE_W-FRAC_BITS){1'b0}}, op.base, {FRAC_BITS{1'b0}}});
    prod     = op.diff * $signed({1'b0, op.mul});
    p_nxt    = base_ext + prod;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      p_r <= p_nxt;
    end
  end

endmodule
`default_nettype wire
